[rtl/kpr_pkg.sv]
package kpr_pkg;

  localparam int KPR_COUNT_WIDTH = 16;
  localparam logic [31:0] KPR_FNV_BASIS = 32'h811c_9dc5;
  localparam logic [31:0] KPR_FNV_PRIME = 32'h0100_0193;
  localparam logic [63:0] KPR_MAG_LIMIT = 64'h8000_0000_0000_0000;
  localparam int KPR_DIV_STEPS = 64;
  localparam int KPR_STEP_W = $clog2(KPR_DIV_STEPS);
  localparam int KPR_QUEUE_DEPTH = 2;
  localparam int KPR_QPTR_W = $clog2(KPR_QUEUE_DEPTH);

  typedef enum logic [1:0] {
    MODE_HASH    = 2'd0,
    MODE_DECIMAL = 2'd1,
    MODE_WORD    = 2'd2,
    MODE_SPARE   = 2'd3
  } kpr_mode_t;

  typedef enum logic [1:0] {
    REG_MODE  = 2'd0,
    REG_COUNT = 2'd1,
    REG_PREFIX = 2'd2,
    REG_LOCAL = 2'd3
  } kpr_reg_t;

  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,
    PH_SIGN   = 2'd1,
    PH_DIGITS = 2'd2,
    PH_STOP   = 2'd3
  } kpr_phase_t;

  typedef enum logic [1:0] {
    B_IDLE = 2'd0,
    B_DIV  = 2'd1,
    B_FIN  = 2'd2,
    B_DONE = 2'd3
  } kpr_bstate_t;

  // One finished key on its way from the front to the back.
  typedef struct packed {
    logic [63:0] value;
    logic        negative;
    logic        error;
  } kpr_entry_t;

endpackage

[rtl/kpr_front.sv]
module kpr_front import kpr_pkg::*; #(
  parameter int COUNT_WIDTH = KPR_COUNT_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  key_byte,
  input  logic        last_byte,
  input  logic [1:0]  partition_mode,
  input  logic [15:0] prefix_bytes,
  output logic        entry_push,
  output kpr_entry_t  entry
);

  logic [31:0]            hash, hash_next;
  logic [COUNT_WIDTH-1:0] cnt, cnt_next;
  logic [31:0]            word, word_next;
  logic [63:0]            mag, mag_next;
  logic                   neg, neg_next;
  kpr_phase_t             phase, phase_next;
  logic                   ovf, ovf_next;

  logic [32:0] cnt_ext;
  logic [31:0] hash_mul;
  logic [67:0] prod;
  logic        is_digit, is_ws;
  logic        dec_err;

  always_comb begin
    cnt_ext  = {{(33-COUNT_WIDTH){1'b0}}, cnt};
    hash_mul = hash * KPR_FNV_PRIME;
    hash_next = (cnt_ext < {17'd0, prefix_bytes}) ? (hash_mul ^ {24'd0, key_byte}) : hash;
    word_next = word;
    if (cnt_ext < 33'd4) begin
      word_next = word | ({24'd0, key_byte} << {cnt[1:0], 3'b000});
    end
    cnt_next = (cnt != {COUNT_WIDTH{1'b1}}) ? cnt + 1'b1 : cnt;

    is_digit = (key_byte >= 8'h30) && (key_byte <= 8'h39);
    is_ws    = (key_byte == 8'h20) || ((key_byte >= 8'h09) && (key_byte <= 8'h0d));
    prod     = {1'b0, mag, 3'b000} + {3'b000, mag, 1'b0} + {64'd0, key_byte[3:0]};
    mag_next   = mag;
    neg_next   = neg;
    phase_next = phase;
    ovf_next   = ovf;
    if (phase == PH_SKIP && is_ws) begin
      phase_next = phase;
    end else if (phase == PH_SKIP && (key_byte == 8'h2b || key_byte == 8'h2d)) begin
      neg_next   = (key_byte == 8'h2d);
      phase_next = PH_SIGN;
    end else if (phase == PH_STOP) begin
      phase_next = phase;
    end else if (!is_digit) begin
      if (phase != PH_DIGITS) begin
        ovf_next = 1'b1;
      end
      phase_next = PH_STOP;
    end else begin
      phase_next = PH_DIGITS;
      // Overflow exactly when ten times the magnitude plus the digit passes 2^63.
      if (prod > {4'd0, KPR_MAG_LIMIT}) begin
        ovf_next = 1'b1;
      end else begin
        mag_next = prod[63:0];
      end
    end

    dec_err = ovf_next || !(phase_next == PH_DIGITS || phase_next == PH_STOP) ||
              (!neg_next && mag_next == KPR_MAG_LIMIT);

    entry_push = accept && last_byte;
    case (partition_mode)
      MODE_DECIMAL: begin
        entry.value    = mag_next;
        entry.negative = neg_next;
        entry.error    = dec_err;
      end
      MODE_WORD: begin
        entry.value    = {32'd0, word_next - 32'd1};
        entry.negative = 1'b0;
        entry.error    = ({{(33-COUNT_WIDTH){1'b0}}, cnt_next} < 33'd4);
      end
      default: begin
        entry.value    = {32'd0, hash_next};
        entry.negative = 1'b0;
        entry.error    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || entry_push) begin
      hash  <= KPR_FNV_BASIS;
      cnt   <= '0;
      word  <= '0;
      mag   <= '0;
      neg   <= 1'b0;
      phase <= PH_SKIP;
      ovf   <= 1'b0;
    end else if (accept) begin
      hash  <= hash_next;
      cnt   <= cnt_next;
      word  <= word_next;
      mag   <= mag_next;
      neg   <= neg_next;
      phase <= phase_next;
      ovf   <= ovf_next;
    end
  end

endmodule

[rtl/kpr_queue.sv]
module kpr_queue import kpr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr_en,
  input  kpr_entry_t wr_entry,
  output logic       q_full,
  input  logic       rd_en,
  output logic       q_valid,
  output kpr_entry_t rd_entry
);

  kpr_entry_t            slots [KPR_QUEUE_DEPTH];
  logic [KPR_QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [KPR_QPTR_W:0]   fill;

  assign q_full   = (fill == (KPR_QPTR_W+1)'(KPR_QUEUE_DEPTH));
  assign q_valid  = (fill != '0);
  assign rd_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill + (KPR_QPTR_W+1)'(wr_en) - (KPR_QPTR_W+1)'(rd_en);
    end
  end

endmodule

[rtl/kpr_back.sv]
module kpr_back import kpr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  kpr_entry_t  q_entry,
  output logic        q_pop,
  input  logic [31:0] partition_count,
  input  logic [31:0] node_partition,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] partition,
  output logic        is_local,
  output logic        parse_error
);

  kpr_bstate_t          state, state_next;
  logic [63:0]          dividend, dividend_next;
  logic [32:0]          rem, rem_next;
  logic [KPR_STEP_W-1:0] step, step_next;
  logic                 neg, neg_next;
  logic [31:0]          part_next;
  logic                 local_next, err_next;
  logic [32:0]          rem_sh;
  logic [31:0]          signed_rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    dividend    <= dividend_next;
    rem         <= rem_next;
    step        <= step_next;
    neg         <= neg_next;
    partition   <= part_next;
    is_local    <= local_next;
    parse_error <= err_next;
  end

  always_comb begin
    state_next    = state;
    dividend_next = dividend;
    rem_next      = rem;
    step_next     = step;
    neg_next      = neg;
    part_next     = partition;
    local_next    = is_local;
    err_next      = parse_error;
    q_pop         = 1'b0;
    rem_sh        = {rem[31:0], dividend[63]};
    signed_rem    = neg ? (32'd0 - rem[31:0]) : rem[31:0];
    empty         = (state != B_DONE);
    case (state)
      B_IDLE: begin
        if (q_valid) begin
          q_pop         = 1'b1;
          neg_next      = q_entry.negative;
          dividend_next = q_entry.value;
          rem_next      = '0;
          step_next     = '0;
          if (q_entry.error) begin
            part_next  = '0;
            local_next = 1'b0;
            err_next   = 1'b1;
            state_next = B_DONE;
          end else if (partition_count == 32'd0) begin
            rem_next   = {1'b0, q_entry.value[31:0]};
            state_next = B_FIN;
          end else begin
            state_next = B_DIV;
          end
        end
      end
      B_DIV: begin
        // One restoring step per cycle, dividend bits taken from the top.
        rem_next      = (rem_sh >= {1'b0, partition_count}) ?
                        rem_sh - {1'b0, partition_count} : rem_sh;
        dividend_next = {dividend[62:0], 1'b0};
        step_next     = step + 1'b1;
        if (step == KPR_STEP_W'(KPR_DIV_STEPS - 1)) begin
          state_next = B_FIN;
        end
      end
      B_FIN: begin
        part_next  = signed_rem;
        local_next = (signed_rem == node_partition);
        err_next   = 1'b0;
        state_next = B_DONE;
      end
      B_DONE: begin
        if (pop) begin
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

endmodule

[rtl/key_partition_router_top.sv]
// Key partition router.
// Key bytes arrive on the input queue port: key_byte with last_byte marking the
// final byte of a key, one transaction per cycle whenever full is low. Each key
// yields one result transaction on the output queue port: partition, is_local
// and parse_error, shown while empty is low and taken with pop.
// The front end hashes, parses and assembles words as the bytes stream in, so
// it sustains one byte per cycle while full is low. A finished key enters a
// two-entry queue; the back end reduces it modulo partition_count with a
// one-bit-per-cycle restoring divider of 64 steps, then the finish state sets
// the result (a zero count skips the divider and keeps the low 32 bits, a key
// in error skips both). The back end takes the next key only after the
// previous result is popped, so the divider can limit the byte rate.
// If the receiver stalls, the result is held and the back end waits; the
// queue then fills, and full is raised until a slot frees up.
// Configuration is written through cfg_valid/cfg_ready; the user must write it
// only while idle, as the block itself does not enforce this. A synchronous
// reset restores the register defaults, clears the per-key trackers and
// empties the queue and the result stage.
module key_partition_router_top import kpr_pkg::*; #(
  parameter int COUNT_WIDTH = KPR_COUNT_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  key_byte,
  input  logic        last_byte,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] partition,
  output logic        is_local,
  output logic        parse_error,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [1:0]  partition_mode;
  logic [31:0] partition_count;
  logic [15:0] prefix_bytes;
  logic [31:0] node_partition;

  logic       accept;
  logic       q_full, q_valid, q_pop, entry_push;
  kpr_entry_t entry, q_entry;

  assign cfg_ready = 1'b1;
  assign full      = q_full;
  assign accept    = push && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      partition_mode  <= MODE_HASH;
      partition_count <= 32'd1;
      prefix_bytes    <= 16'hffff;
      node_partition  <= 32'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MODE:   partition_mode  <= cfg_data[1:0];
        REG_COUNT:  partition_count <= cfg_data;
        REG_PREFIX: prefix_bytes    <= cfg_data[15:0];
        REG_LOCAL:  node_partition  <= cfg_data;
        default:    partition_mode  <= partition_mode;
      endcase
    end
  end

  kpr_front #(.COUNT_WIDTH(COUNT_WIDTH)) u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .key_byte       (key_byte),
    .last_byte      (last_byte),
    .partition_mode (partition_mode),
    .prefix_bytes   (prefix_bytes),
    .entry_push     (entry_push),
    .entry          (entry)
  );

  kpr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (entry_push),
    .wr_entry (entry),
    .q_full   (q_full),
    .rd_en    (q_pop),
    .q_valid  (q_valid),
    .rd_entry (q_entry)
  );

  kpr_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_entry         (q_entry),
    .q_pop           (q_pop),
    .partition_count (partition_count),
    .node_partition  (node_partition),
    .empty           (empty),
    .pop             (pop),
    .partition       (partition),
    .is_local        (is_local),
    .parse_error     (parse_error)
  );

endmodule

[rtl/kpr_checker.sv]
module kpr_checker (
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        pop,
  input logic [31:0] partition,
  input logic        is_local,
  input logic        parse_error
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result waiting after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(partition) && $stable(parse_error)))
    else $error("stalled result changed");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && parse_error) |-> (partition == 32'd0 && !is_local))
    else $error("error result carries a partition");

  a_pop_gap: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop) |=> empty)
    else $error("back-to-back results faster than the back end allows");

endmodule

bind key_partition_router_top kpr_checker u_kpr_checker (
  .clk         (clk),
  .rst         (rst),
  .empty       (empty),
  .pop         (pop),
  .partition   (partition),
  .is_local    (is_local),
  .parse_error (parse_error)
);

[tb/key_partition_router_top_test.sv]
`timescale 1ns / 100ps

module key_partition_router_top_test;
  import kpr_pkg::*;

  // Largest saturating byte position, matching the block's default counter width.
  localparam int unsigned POS_MAX = (1 << KPR_COUNT_WIDTH) - 1;
  localparam int unsigned CYCLE_LIMIT = 200_000;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [7:0]  key_byte;
  logic        last_byte;
  logic        empty;
  logic        pop;
  logic [31:0] partition;
  logic        is_local;
  logic        parse_error;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  key_partition_router_top i_dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .key_byte(key_byte), .last_byte(last_byte),
    .empty(empty), .pop(pop), .partition(partition), .is_local(is_local),
    .parse_error(parse_error),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  typedef struct packed {
    logic [31:0] partition;
    logic        is_local;
    logic        parse_error;
  } route_t;

  // The testbench's own copy of the registers.
  kpr_mode_t   mode_q;
  logic [31:0] count_q;
  logic [15:0] prefix_q;
  logic [31:0] local_q;

  // The testbench's own copy of the per-key trackers.
  logic [31:0] fnv_acc;
  logic [31:0] pos_acc;
  logic [31:0] word_acc;
  logic [63:0] mag_acc;
  logic        neg_acc;
  kpr_phase_t  phase_acc;
  logic        bad_acc;

  route_t      routes_due[$];
  bit          failed = 1'b0;
  bit          quiet;      // no idling on either side in the final part
  int unsigned cycle_count = 0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Guards against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic void clear_trackers();
    fnv_acc   = KPR_FNV_BASIS;
    pos_acc   = 0;
    word_acc  = 0;
    mag_acc   = 0;
    neg_acc   = 1'b0;
    phase_acc = PH_SKIP;
    bad_acc   = 1'b0;
  endfunction

  function automatic logic [31:0] reduce_mod(logic [63:0] v);
    if (count_q == 0)
      return v[31:0];
    return 32'(v % {32'd0, count_q});
  endfunction

  // Follows the stoll-style parse for one byte.
  function automatic void parse_decimal(logic [7:0] b);
    bit          digit;
    logic [63:0] d;
    digit = (b >= 8'h30 && b <= 8'h39);
    d = {60'd0, 4'(b - 8'h30)};
    if (phase_acc == PH_SKIP) begin
      if (b == 8'h20 || (b >= 8'h09 && b <= 8'h0d))
        return;
      if (b == "+" || b == "-") begin
        neg_acc = (b == "-");
        phase_acc = PH_SIGN;
        return;
      end
    end
    if (phase_acc == PH_STOP)
      return;
    if (!digit) begin
      if (phase_acc != PH_DIGITS)
        bad_acc = 1'b1;
      phase_acc = PH_STOP;
      return;
    end
    phase_acc = PH_DIGITS;
    if (mag_acc > (KPR_MAG_LIMIT - d) / 10)
      bad_acc = 1'b1;
    else
      mag_acc = mag_acc * 10 + d;
  endfunction

  // Advances the trackers by one byte and, on a closing byte, queues the route due.
  function automatic void predict_route(logic [7:0] b, logic last);
    route_t      r;
    logic [31:0] p;
    bit          err;
    p = 0;
    err = 0;
    if (pos_acc < prefix_q)
      fnv_acc = (fnv_acc * KPR_FNV_PRIME) ^ {24'd0, b};
    if (pos_acc < 4)
      word_acc = word_acc | ({24'd0, b} << (8 * pos_acc));
    parse_decimal(b);
    if (pos_acc < POS_MAX)
      pos_acc = pos_acc + 1;
    if (!last)
      return;
    case (mode_q)
      MODE_DECIMAL: begin
        if (phase_acc != PH_DIGITS && phase_acc != PH_STOP)
          bad_acc = 1'b1;
        if (bad_acc || (!neg_acc && mag_acc == KPR_MAG_LIMIT)) begin
          err = 1;
        end else begin
          p = reduce_mod(mag_acc);
          if (neg_acc)
            p = 32'd0 - p;
        end
      end
      MODE_WORD: begin
        if (pos_acc < 4)
          err = 1;
        else
          p = reduce_mod({32'd0, word_acc - 32'd1});
      end
      default: p = reduce_mod({32'd0, fnv_acc});
    endcase
    r.partition   = err ? 32'd0 : p;
    r.is_local    = !err && p == local_q;
    r.parse_error = err;
    routes_due.push_back(r);
    clear_trackers();
  endfunction

  // Pops results with random stall bursts and compares them with the routes due.
  initial begin
    route_t exp_r;
    int     stall;
    pop = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        if (routes_due.size() == 0) begin
          $display("%0t: result with nothing due, got %h/%b/%b", $time,
                   partition, is_local, parse_error);
          failed = 1;
        end else begin
          exp_r = routes_due.pop_front();
          if (partition !== exp_r.partition) begin
            $display("%0t: partition expected %h actual %h", $time,
                     exp_r.partition, partition);
            failed = 1;
          end
          if (is_local !== exp_r.is_local) begin
            $display("%0t: is_local expected %b actual %b", $time,
                     exp_r.is_local, is_local);
            failed = 1;
          end
          if (parse_error !== exp_r.parse_error) begin
            $display("%0t: parse_error expected %b actual %b", $time,
                     exp_r.parse_error, parse_error);
            failed = 1;
          end
        end
      end
      if (stall > 0) begin
        stall--;
        pop <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(0, 7);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Sends one key byte; a random idle burst may come first. push is left high
  // after the byte is taken and dropped by the next idle burst or by drain.
  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 8);
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push      <= 1'b1;
    key_byte  <= b;
    last_byte <= last;
    do @(posedge clk); while (full);
    predict_route(b, last);
  endtask

  task automatic send_key(input logic [7:0] bytes[$]);
    foreach (bytes[i])
      send_byte(bytes[i], i == bytes.size() - 1);
  endtask

  task automatic send_text(string s);
    logic [7:0] q[$];
    foreach (s[i])
      q.push_back(s[i]);
    send_key(q);
  endtask

  // Stops sending, waits until every route due has come out, then lets the
  // divider drain.
  task automatic drain();
    push <= 1'b0;
    while (routes_due.size() != 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // Register writes happen only while the block is idle; cfg_valid is dropped
  // by configure after the last write.
  task automatic write_reg(kpr_reg_t idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MODE:   mode_q   = kpr_mode_t'(val[1:0]);
      REG_COUNT:  count_q  = val;
      REG_PREFIX: prefix_q = val[15:0];
      default:    local_q  = val;
    endcase
  endtask

  task automatic configure(kpr_mode_t m, logic [31:0] c, logic [15:0] pf, logic [31:0] lp);
    drain();
    write_reg(REG_MODE, {30'd0, m});
    write_reg(REG_COUNT, c);
    write_reg(REG_PREFIX, {16'd0, pf});
    write_reg(REG_LOCAL, lp);
    cfg_valid <= 1'b0;
  endtask

  // Directed keys covering each mode and its corner cases.
  task automatic test_directed();
    // Reset configuration: hash mode, one partition, so everything is local.
    send_text("a");
    send_key('{8'h00});
    send_key('{8'hff, 8'h80, 8'h7f});
    configure(MODE_HASH, 32'd0, 16'd2, 32'd0);
    send_text("abcdef");             // only a two-byte prefix hashed, no reduction
    configure(MODE_HASH, 32'd7, 16'd0, 32'd3);
    send_text("xyz");                // empty prefix, basis reduced
    configure(MODE_DECIMAL, 32'd1000, 16'hffff, 32'd42);
    send_text("42");
    send_text(" \t\n\v\f\r-17");     // whitespace and a negative value
    send_text("+9223372036854775807");
    send_text("9223372036854775808");   // just too large
    send_text("-9223372036854775808");  // the most negative value
    send_text("99999999999999999999");  // overflow
    send_text("12abc");              // parse stops at the letter
    send_text("-");                  // sign without a digit
    send_text("  ");                 // nothing but whitespace
    send_text("x5");
    send_text("+-3");
    configure(MODE_DECIMAL, 32'd0, 16'hffff, 32'hffff_ffef);
    send_text("-17");                // unreduced negative
    configure(MODE_WORD, 32'hffff_ffff, 16'hffff, 32'd0);
    send_key('{8'h01, 8'h00, 8'h00, 8'h00});
    send_key('{8'h00, 8'h00, 8'h00, 8'h00, 8'h55}); // id zero wraps
    send_key('{8'h12, 8'h34, 8'h56});               // too short
    configure(MODE_SPARE, 32'd5, 16'hffff, 32'd1);   // spare mode acts as hash
    send_text("spare");
  endtask

  function automatic logic [7:0] random_char(kpr_mode_t m);
    int k;
    k = $urandom_range(0, 15);
    if (m == MODE_DECIMAL && k < 12)
      return 8'h30 + 8'($urandom_range(0, 9));
    if (m == MODE_DECIMAL && k == 12)
      return $urandom_range(0, 1) ? "-" : "+";
    if (m == MODE_DECIMAL && k == 13)
      return $urandom_range(0, 1) ? 8'h20 : 8'($urandom_range(9, 13));
    return 8'($urandom);
  endfunction

  // Random keys over several settings; decimal keys are mostly well formed.
  task automatic test_random();
    kpr_mode_t  m;
    logic [7:0] q[$];
    int         len;
    int         sent;
    sent = 0;
    for (int phase = 0; phase < 10; phase++) begin
      m = kpr_mode_t'($urandom_range(0, 3));
      case ($urandom_range(0, 3))
        0: configure(m, 32'd0, 16'($urandom), $urandom);
        1: configure(m, 32'hffff_ffff, 16'($urandom_range(0, 8)), $urandom_range(0, 3));
        default: configure(m, $urandom_range(1, 9), 16'($urandom_range(0, 12)),
                           $urandom_range(0, 9));
      endcase
      if (phase == 8)
        quiet = 1;
      while (sent < (phase + 1) * 5) begin
        q.delete();
        len = $urandom_range(1, 22);
        if (m == MODE_DECIMAL && $urandom_range(0, 3) != 0) begin
          if ($urandom_range(0, 1))
            q.push_back("-");
          for (int i = 0; i < len; i++)
            q.push_back(8'h30 + 8'($urandom_range(0, 9)));
        end else begin
          for (int i = 0; i < len; i++)
            q.push_back(random_char(m));
        end
        send_key(q);
        sent++;
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    push = 1'b0;
    key_byte = 8'd0;
    last_byte = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_MODE;
    cfg_data = 32'd0;
    quiet = 0;
    mode_q = MODE_HASH;
    count_q = 32'd1;
    prefix_q = 16'hffff;
    local_q = 32'd0;
    clear_trackers();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    drain();
    if (!failed) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
